[hdl/assert_macros.svh]
// assertion helpers shared by the rtl, clocked on i_clk, quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

[hdl/mpq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

    localparam int LEVELS_DEF     = 16;
    localparam int CAPACITY_DEF   = 64;
    localparam int ELEM_WIDTH_DEF = 32;

    localparam int LEVEL_W  = 4;
    localparam int STATUS_W = 2;

    localparam logic [LEVEL_W-1:0] LOWEST_RESET = 4'd15;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEVEL = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ0,
        S_ENQ1,
        S_DEQ0,
        S_DEQ1,
        S_DEQ2,
        S_SCAN,
        S_HEAD0,
        S_HEAD1,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[hdl/mpq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module mpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/multilevel_priority_queue_top.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Priority queue with one FIFO per level (level 0 most urgent) over a shared
// store of CAPACITY slots, linked through simple dual-port memories with
// registered reads. One transaction is worked on at a time; a dequeue that
// empties the most urgent level adds a search for the next non-empty level,
// one level per cycle; rejected and empty-queue transactions finish sooner
// than accepted ones. The time each takes is set by the chained registered
// reads of the head link and element memories and by the level search. Every
// transaction returns one result with the queue state after it; the result sits
// in an output register, so a new transaction is taken while it waits. The free
// slot FIFO needs no clearing pass after reset: a fill count marks entries that
// still hold their initial slot number. lowest_level is to be changed only while
// the queue is empty; the block itself does not enforce it.
module multilevel_priority_queue_top #(
    parameter int LEVELS     = mpq_pkg::LEVELS_DEF,
    parameter int CAPACITY   = mpq_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = mpq_pkg::ELEM_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mpq_pkg::LEVEL_W-1:0]        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_operation,
    input  logic [ELEM_WIDTH-1:0]              i_element,
    input  logic [mpq_pkg::LEVEL_W-1:0]        i_level,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [mpq_pkg::STATUS_W-1:0]       o_status,
    output logic [ELEM_WIDTH-1:0]              o_removed_element,
    output logic [ELEM_WIDTH-1:0]              o_head_element,
    output logic [mpq_pkg::LEVEL_W-1:0]        o_head_level,
    output logic [$clog2(CAPACITY+1)-1:0]      o_count,
    output logic                               o_is_empty
);

    import mpq_pkg::*;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int LVL_AW = $clog2(LEVELS);
    localparam int CNT_W  = $clog2(CAPACITY+1);

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [ELEM_WIDTH-1:0] r_elem, n_elem;
    logic [LEVEL_W-1:0]    r_level, n_level;
    t_status               r_status, n_status;
    logic [ELEM_WIDTH-1:0] r_removed, n_removed;
    logic [LEVEL_W-1:0]    r_lowest, n_lowest;
    logic [LEVELS-1:0]     r_nonempty, n_nonempty;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [LEVEL_W-1:0]    r_best, n_best;
    logic [LEVEL_W-1:0]    r_scan, n_scan;
    logic [SLOT_W-1:0]     r_free_rd, n_free_rd;
    logic [CNT_W-1:0]      r_fill, n_fill;

    logic                  r_out_valid, n_out_valid;
    t_status               r_o_status, n_o_status;
    logic [ELEM_WIDTH-1:0] r_o_removed, n_o_removed;
    logic [ELEM_WIDTH-1:0] r_o_head_elem, n_o_head_elem;
    logic [LEVEL_W-1:0]    r_o_head_level, n_o_head_level;
    logic [CNT_W-1:0]      r_o_count, n_o_count;
    logic                  r_o_empty, n_o_empty;

    logic [LVL_AW-1:0]     lvl_idx, best_idx, scan_idx;
    logic                  reject, full, fl_fresh, last;
    logic                  idle_busy;
    logic [SLOT_W-1:0]     new_slot, rd_next, free_wr_pos;
    logic [SLOT_W:0]       free_wr_sum;
    logic [CNT_W-1:0]      cnt_dec;

    logic                  es_we, nl_we, lh_we, lt_we, fl_we;
    logic [LVL_AW-1:0]     lh_waddr, lt_raddr;
    logic [SLOT_W-1:0]     lh_wdata;
    logic [ELEM_WIDTH-1:0] es_rdata;
    logic [SLOT_W-1:0]     nl_rdata, lh_rdata, lt_rdata, fl_rdata;

    assign lvl_idx  = LVL_AW'(r_level);
    assign best_idx = LVL_AW'(r_best);
    assign scan_idx = LVL_AW'(r_scan);

    assign reject   = (r_level > r_lowest) || (32'(r_level) >= LEVELS);
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign fl_fresh = (CNT_W'(r_free_rd) >= r_fill);
    assign new_slot = fl_fresh ? r_free_rd : fl_rdata;
    assign rd_next  = (r_free_rd == SLOT_W'(CAPACITY-1)) ? '0 : r_free_rd + 1'b1;
    assign cnt_dec  = r_count - 1'b1;
    assign last     = (lh_rdata == lt_rdata);

    assign idle_busy = (r_state == S_IDLE) && (r_count != '0);

    // tail of the free slot fifo
    assign free_wr_sum = (SLOT_W+1)'(r_free_rd) + (SLOT_W+1)'(CNT_W'(CAPACITY) - r_count);
    assign free_wr_pos = (free_wr_sum >= (SLOT_W+1)'(CAPACITY))
                       ? SLOT_W'(free_wr_sum - (SLOT_W+1)'(CAPACITY))
                       : SLOT_W'(free_wr_sum);

    assign lt_raddr = (r_op == OP_ENQ) ? lvl_idx : best_idx;

    mpq_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(CAPACITY)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (es_we),
        .i_waddr (new_slot),
        .i_wdata (r_elem),
        .i_raddr (lh_rdata),
        .o_rdata (es_rdata)
    );

    mpq_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (nl_we),
        .i_waddr (lt_rdata),
        .i_wdata (new_slot),
        .i_raddr (lh_rdata),
        .o_rdata (nl_rdata)
    );

    mpq_ram #(.WIDTH(SLOT_W), .DEPTH(LEVELS)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (lh_we),
        .i_waddr (lh_waddr),
        .i_wdata (lh_wdata),
        .i_raddr (best_idx),
        .o_rdata (lh_rdata)
    );

    mpq_ram #(.WIDTH(SLOT_W), .DEPTH(LEVELS)) u_tail_ram (
        .i_clk   (i_clk),
        .i_we    (lt_we),
        .i_waddr (lvl_idx),
        .i_wdata (new_slot),
        .i_raddr (lt_raddr),
        .o_rdata (lt_rdata)
    );

    mpq_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_waddr (free_wr_pos),
        .i_wdata (lh_rdata),
        .i_raddr (r_free_rd),
        .o_rdata (fl_rdata)
    );

    always_comb begin
        n_state        = r_state;
        n_op           = r_op;
        n_elem         = r_elem;
        n_level        = r_level;
        n_status       = r_status;
        n_removed      = r_removed;
        n_lowest       = r_lowest;
        n_nonempty     = r_nonempty;
        n_count        = r_count;
        n_best         = r_best;
        n_scan         = r_scan;
        n_free_rd      = r_free_rd;
        n_fill         = r_fill;
        n_out_valid    = r_out_valid && i_out_stall;
        n_o_status     = r_o_status;
        n_o_removed    = r_o_removed;
        n_o_head_elem  = r_o_head_elem;
        n_o_head_level = r_o_head_level;
        n_o_count      = r_o_count;
        n_o_empty      = r_o_empty;
        es_we          = 1'b0;
        nl_we          = 1'b0;
        lh_we          = 1'b0;
        lt_we          = 1'b0;
        fl_we          = 1'b0;
        lh_waddr       = lvl_idx;
        lh_wdata       = new_slot;

        if (i_cfg_we) begin
            n_lowest = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = t_op'(i_operation);
                    n_elem    = i_element;
                    n_level   = i_level;
                    n_status  = ST_OK;
                    n_removed = '0;
                    n_state   = (t_op'(i_operation) == OP_DEQ) ? S_DEQ0 : S_ENQ0;
                end
            end
            S_ENQ0: begin
                if (reject) begin
                    n_status = ST_BAD_LEVEL;
                    n_state  = (r_count == '0) ? S_DONE : S_HEAD0;
                end else if (full) begin
                    n_status = ST_FULL;
                    n_state  = S_HEAD0;
                end else begin
                    n_state = S_ENQ1;
                end
            end
            S_ENQ1: begin
                es_we = 1'b1;
                lt_we = 1'b1;
                if (r_nonempty[lvl_idx]) begin
                    nl_we = 1'b1;
                end else begin
                    lh_we = 1'b1;
                end
                n_nonempty[lvl_idx] = 1'b1;
                if (r_count == '0 || r_level < r_best) begin
                    n_best = r_level;
                end
                n_count   = r_count + 1'b1;
                n_free_rd = rd_next;
                n_state   = S_HEAD0;
            end
            S_DEQ0: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_DEQ1;
                end
            end
            S_DEQ1: begin
                n_state = S_DEQ2;
            end
            S_DEQ2: begin
                n_removed = es_rdata;
                if (last) begin
                    n_nonempty[best_idx] = 1'b0;
                end else begin
                    lh_we    = 1'b1;
                    lh_waddr = best_idx;
                    lh_wdata = nl_rdata;
                end
                fl_we = 1'b1;
                if (r_fill != CNT_W'(CAPACITY)) begin
                    n_fill = r_fill + 1'b1;
                end
                n_count = cnt_dec;
                if (cnt_dec == '0) begin
                    n_best  = '0;
                    n_state = S_DONE;
                end else if (last) begin
                    n_scan  = r_best;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_HEAD0;
                end
            end
            S_SCAN: begin
                if (r_nonempty[scan_idx]) begin
                    n_best  = r_scan;
                    n_state = S_HEAD0;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_HEAD0: begin
                n_state = S_HEAD1;
            end
            S_HEAD1: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid    = 1'b1;
                    n_o_status     = r_status;
                    n_o_removed    = r_removed;
                    n_o_head_elem  = (r_count == '0) ? '0 : es_rdata;
                    n_o_head_level = (r_count == '0) ? '0 : r_best;
                    n_o_count      = r_count;
                    n_o_empty      = (r_count == '0);
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lowest    <= LOWEST_RESET;
            r_nonempty  <= '0;
            r_count     <= '0;
            r_best      <= '0;
            r_free_rd   <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lowest    <= n_lowest;
            r_nonempty  <= n_nonempty;
            r_count     <= n_count;
            r_best      <= n_best;
            r_free_rd   <= n_free_rd;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op           <= n_op;
        r_elem         <= n_elem;
        r_level        <= n_level;
        r_status       <= n_status;
        r_removed      <= n_removed;
        r_scan         <= n_scan;
        r_o_status     <= n_o_status;
        r_o_removed    <= n_o_removed;
        r_o_head_elem  <= n_o_head_elem;
        r_o_head_level <= n_o_head_level;
        r_o_count      <= n_o_count;
        r_o_empty      <= n_o_empty;
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_o_status;
    assign o_removed_element = r_o_removed;
    assign o_head_element    = r_o_head_elem;
    assign o_head_level      = r_o_head_level;
    assign o_count           = r_o_count;
    assign o_is_empty        = r_o_empty;

    `ASSERT_IMPLY(a_empty_no_levels, r_count == '0, r_nonempty == '0, "levels marked while empty")
    `ASSERT_IMPLY(a_best_nonempty, idle_busy, r_nonempty[best_idx], "best level is empty")
    `ASSERT_IMPLY(a_scan_has_items, r_state == S_SCAN, r_count != '0, "search on empty queue")
    `ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(CAPACITY), "count beyond capacity")
    `ASSERT_ALWAYS(a_fill_bound, r_fill <= CNT_W'(CAPACITY), "fill beyond capacity")

endmodule

`default_nettype wire

[tb/sv/multilevel_priority_queue_top_tb.sv]
`timescale 1ns / 1ps

module multilevel_priority_queue_top_tb;
    import mpq_pkg::*;

    localparam int LEVELS   = LEVELS_DEF;
    localparam int CAP      = CAPACITY_DEF;
    localparam int EW       = ELEM_WIDTH_DEF;
    localparam int CNT_W    = $clog2(CAP + 1);
    localparam int LIMIT    = 600000;
    localparam int N_ITEMS  = 1100;
    localparam int LONG_HOLD = 300;

    typedef struct {
        t_status             status;
        logic [EW-1:0]       removed;
        logic [EW-1:0]       head_elem;
        logic [LEVEL_W-1:0]  head_lvl;
        logic [CNT_W-1:0]    count;
        logic                empty;
    } t_reply;

    class mpq_scoreboard;
        logic [EW-1:0]      slot_value[CAP];
        int                 slot_next[CAP];
        int                 lvl_head[LEVELS];
        int                 lvl_tail[LEVELS];
        bit [LEVELS-1:0]    lvl_busy;
        int                 free_slots[CAP];
        int                 free_rd;
        int                 depth;
        int                 best;
        logic [LEVEL_W-1:0] lowest;
        t_reply             replies[$];
        int                 errors;

        function new();
            for (int i = 0; i < CAP; i++) begin
                slot_value[i] = '0;
                slot_next[i]  = 0;
                free_slots[i] = i;
            end
            for (int i = 0; i < LEVELS; i++) begin
                lvl_head[i] = 0;
                lvl_tail[i] = 0;
            end
            lvl_busy = '0;
            free_rd  = 0;
            depth    = 0;
            best     = 0;
            lowest   = LOWEST_RESET;
            errors   = 0;
        endfunction

        function void set_lowest(logic [LEVEL_W-1:0] v);
            lowest = v;
        endfunction

        function int pending();
            return replies.size();
        endfunction

        function void note_request(t_op op, logic [EW-1:0] elem, logic [LEVEL_W-1:0] lvl);
            t_reply r;
            int slot;
            int b;
            int p;
            r.status  = ST_OK;
            r.removed = '0;
            if (op == OP_ENQ) begin
                if (lvl > lowest) begin
                    r.status = ST_BAD_LEVEL;
                end else if (depth >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    slot = free_slots[free_rd];
                    free_rd = (free_rd + 1) % CAP;
                    slot_value[slot] = elem;
                    slot_next[slot] = 0;
                    if (lvl_busy[lvl]) begin
                        slot_next[lvl_tail[lvl]] = slot;
                    end else begin
                        lvl_head[lvl] = slot;
                    end
                    lvl_tail[lvl] = slot;
                    lvl_busy[lvl] = 1'b1;
                    if (depth == 0 || int'(lvl) < best) begin
                        best = int'(lvl);
                    end
                    depth++;
                end
            end else if (depth == 0) begin
                r.status = ST_EMPTY;
            end else begin
                b = best;
                slot = lvl_head[b];
                r.removed = slot_value[slot];
                if (slot == lvl_tail[b]) begin
                    lvl_busy[b] = 1'b0;
                end else begin
                    lvl_head[b] = slot_next[slot];
                end
                free_slots[(free_rd + CAP - depth) % CAP] = slot;
                depth--;
                if (depth == 0) begin
                    best = 0;
                end else if (!lvl_busy[b]) begin
                    p = b;
                    while (p < LEVELS && !lvl_busy[p]) p++;
                    best = (p < LEVELS) ? p : 0;
                end
            end
            r.empty     = (depth == 0);
            r.count     = CNT_W'(depth);
            r.head_lvl  = r.empty ? '0 : LEVEL_W'(best);
            r.head_elem = r.empty ? '0 : slot_value[lvl_head[best]];
            replies.push_back(r);
        endfunction

        function void check_field(string name, logic [EW-1:0] want, logic [EW-1:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(t_reply got);
            t_reply want;
            if (replies.size() == 0) begin
                $error("result transaction with nothing pending");
                errors++;
                return;
            end
            want = replies.pop_front();
            check_field("status", EW'(want.status), EW'(got.status));
            check_field("removed_element", want.removed, got.removed);
            check_field("head_element", want.head_elem, got.head_elem);
            check_field("head_level", EW'(want.head_lvl), EW'(got.head_lvl));
            check_field("count", EW'(want.count), EW'(got.count));
            check_field("is_empty", EW'(want.empty), EW'(got.empty));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [LEVEL_W-1:0]   i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_operation = 1'b0;
    logic [EW-1:0]        i_element = '0;
    logic [LEVEL_W-1:0]   i_level = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [EW-1:0]        o_removed_element;
    logic [EW-1:0]        o_head_element;
    logic [LEVEL_W-1:0]   o_head_level;
    logic [CNT_W-1:0]     o_count;
    logic                 o_is_empty;

    mpq_scoreboard sb = new();

    int unsigned  cycle_count = 0;
    int           items_sent = 0;
    logic [LEVEL_W-1:0] cur_lowest = LOWEST_RESET;
    bit           quiet = 1'b0;
    int           hold_requests = 0;
    int           holds_served = 0;
    int           hold_left = 0;
    int           stall_left = 0;

    multilevel_priority_queue_top #(
        .LEVELS     (LEVELS),
        .CAPACITY   (CAP),
        .ELEM_WIDTH (EW)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_element         (i_element),
        .i_level           (i_level),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_removed_element (o_removed_element),
        .o_head_element    (o_head_element),
        .o_head_level      (o_head_level),
        .o_count           (o_count),
        .o_is_empty        (o_is_empty)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("multilevel_priority_queue_top_tb: done, errors");
            $finish;
        end
    end

    // result side: check accepted transactions, then choose the next stall
    always @(posedge i_clk) begin
        t_reply got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.status    = t_status'(o_status);
            got.removed   = o_removed_element;
            got.head_elem = o_head_element;
            got.head_lvl  = o_head_level;
            got.count     = o_count;
            got.empty     = o_is_empty;
            sb.check_reply(got);
        end
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        if ($urandom_range(0, 99) < 85) return LEVEL_W'($urandom_range(0, cur_lowest));
        return LEVEL_W'($urandom_range(0, LEVELS - 1));
    endfunction

    function automatic logic [EW-1:0] pick_elem();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return $urandom;
    endfunction

    task automatic push_item(t_op op, logic [EW-1:0] elem, logic [LEVEL_W-1:0] lvl);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_element   <= elem;
        i_level     <= lvl;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(op, elem, lvl);
        items_sent++;
    endtask

    task automatic pause_sender(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_and_config(logic [LEVEL_W-1:0] v);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_lowest(v);
        cur_lowest = v;
    endtask

    task automatic random_op(int enq_pct);
        if ($urandom_range(0, 99) < enq_pct) begin
            push_item(OP_ENQ, pick_elem(), pick_level());
        end else begin
            push_item(OP_DEQ, pick_elem(), LEVEL_W'($urandom_range(0, LEVELS - 1)));
        end
        pause_sender(pick_gap());
    endtask

    initial begin
        int phase;
        int len;
        int enq_pct;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        drain_and_config(4'd15);
        push_item(OP_DEQ, 32'hDEAD_BEEF, 4'd3);
        push_item(OP_ENQ, 32'hFFFF_FFFF, 4'd15);
        push_item(OP_ENQ, 32'h0000_0000, 4'd0);
        pause_sender(2);
        push_item(OP_ENQ, 32'hA5A5_A5A5, 4'd7);
        push_item(OP_ENQ, 32'h5A5A_5A5A, 4'd0);
        push_item(OP_ENQ, 32'h1234_5678, 4'd7);
        repeat (5) push_item(OP_DEQ, 32'h0, 4'd0);
        push_item(OP_DEQ, 32'hFFFF_FFFF, 4'd15);

        drain_and_config(4'd0);
        push_item(OP_ENQ, 32'h0000_0011, 4'd1);
        push_item(OP_ENQ, 32'h0000_0022, 4'd15);
        push_item(OP_ENQ, 32'h0000_0033, 4'd0);
        push_item(OP_ENQ, 32'h0000_0044, 4'd0);

        // level limit moves while elements are still queued
        drain_and_config(4'd3);
        push_item(OP_ENQ, 32'h0000_0055, 4'd3);
        push_item(OP_ENQ, 32'h0000_0066, 4'd4);
        drain_and_config(4'd1);
        push_item(OP_ENQ, 32'h0000_0077, 4'd2);
        repeat (4) push_item(OP_DEQ, 32'h0, 4'd0);

        phase = 0;
        while (items_sent < N_ITEMS) begin
            case (phase % 4)
                0: drain_and_config(4'd15);
                2: drain_and_config(4'd0);
                default: drain_and_config(LEVEL_W'($urandom_range(0, LEVELS - 1)));
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            if (phase % 5 == 1) begin
                // fill past capacity, then drain past empty
                repeat (CAP + 4) begin
                    push_item(OP_ENQ, pick_elem(), LEVEL_W'($urandom_range(0, cur_lowest)));
                    pause_sender(pick_gap());
                end
                repeat (CAP + 6) begin
                    push_item(OP_DEQ, pick_elem(), pick_level());
                    pause_sender(pick_gap());
                end
            end else begin
                if (phase == 3) begin
                    quiet = 1'b1;
                    hold_requests++;
                end
                len = $urandom_range(40, 90);
                enq_pct = $urandom_range(20, 90);
                repeat (len) random_op(enq_pct);
            end
            phase++;
        end

        i_in_valid <= 1'b0;
        quiet = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("multilevel_priority_queue_top_tb: done, clean");
        end else begin
            $display("multilevel_priority_queue_top_tb: done, errors");
        end
        $finish;
    end

endmodule
